>>> hw/rtl/csq_pkg.sv
`timescale 1ns / 1ps

package csq_pkg;

  // Sizing of the semaphore.
  localparam int QueueDepth   = 16;
  localparam int ThreadIdBits = 8;
  localparam int CountBits    = 16;

  // Derived widths.
  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int OccBits = $clog2(QueueDepth + 1);
  localparam int CntBits = CountBits + 2;

  // Masks applied to the request fields before use.
  localparam logic [15:0] InitMask =
    (CountBits >= 16) ? 16'hFFFF : 16'((64'd1 << CountBits) - 64'd1);
  localparam logic [7:0] IdMask =
    (ThreadIdBits >= 8) ? 8'hFF : 8'((32'd1 << ThreadIdBits) - 32'd1);

  // Request type codes as they arrive on the input.
  localparam logic [1:0] ReqOpen   = 2'd0;
  localparam logic [1:0] ReqWait   = 2'd1;
  localparam logic [1:0] ReqSignal = 2'd2;
  localparam logic [1:0] ReqClose  = 2'd3;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_WAIT,
    OP_SIGNAL,
    OP_CLOSE
  } csq_op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_CLOSED = 2'd1,
    STATUS_FULL   = 2'd2
  } csq_status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_DRAIN
  } csq_back_state_e;

  // One request as it arrives.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] init_count;
    logic [7:0]  thread_id;
  } csq_req_t;

  // One result as it leaves.
  typedef struct packed {
    csq_status_e status;
    logic        blocked;
    logic        released_valid;
    logic [7:0]  released_thread;
    logic        last;
  } csq_res_t;

  // A classified request waiting between front and back.
  typedef struct packed {
    csq_op_e     op;
    logic [15:0] init_count;
    logic [7:0]  thread_id;
  } csq_cmd_t;

  // Handshake between the front queue and the back unit.
  typedef struct packed {
    logic     valid;
    csq_cmd_t cmd;
  } csq_cmdq_t;

endpackage

>>> hw/rtl/csq_ram.sv
`timescale 1ns / 1ps

module csq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/csq_front.sv
`timescale 1ns / 1ps

module csq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  csq_pkg::csq_req_t req_i,
  output logic              busy_o,
  output csq_pkg::csq_cmdq_t cmdq_o,
  input  logic              pop_i
);

  csq_pkg::csq_cmd_t entry_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        fill_q, fill_d;
  logic              push;
  logic              pop;
  csq_pkg::csq_cmd_t cmd_new;

  // Classify the incoming request type.
  always_comb begin
    cmd_new.init_count = req_i.init_count;
    cmd_new.thread_id  = req_i.thread_id;
    unique case (req_i.req_type)
      csq_pkg::ReqOpen:   cmd_new.op = csq_pkg::OP_OPEN;
      csq_pkg::ReqWait:   cmd_new.op = csq_pkg::OP_WAIT;
      csq_pkg::ReqSignal: cmd_new.op = csq_pkg::OP_SIGNAL;
      csq_pkg::ReqClose:  cmd_new.op = csq_pkg::OP_CLOSE;
    endcase
  end

  // Two-entry request queue toward the back unit.
  assign busy_o = (fill_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (fill_q != 2'd0);

  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop ? ~rd_q : rd_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= cmd_new;
    end
  end

  assign cmdq_o.valid = (fill_q != 2'd0);
  assign cmdq_o.cmd   = entry_q[rd_q];

endmodule

>>> hw/rtl/csq_back.sv
`timescale 1ns / 1ps

module csq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csq_pkg::csq_cmdq_t cmdq_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output csq_pkg::csq_res_t  res_o
);

  localparam logic signed [csq_pkg::CntBits-1:0] CountMax =
    {1'b0, {(csq_pkg::CntBits-1){1'b1}}};

  csq_pkg::csq_back_state_e state_q, state_d;
  logic signed [csq_pkg::CntBits-1:0] count_q, count_d;
  logic signed [csq_pkg::CntBits-1:0] count_inc;
  logic                               open_q, open_d;
  logic [csq_pkg::PtrBits-1:0]        head_q, head_d;
  logic [csq_pkg::PtrBits-1:0]        tail_q, tail_d;
  logic [csq_pkg::OccBits-1:0]        occ_q, occ_d;
  logic                               res_valid_q, res_valid_d;
  csq_pkg::csq_res_t                  res_q, res_d;

  logic                                we;
  logic                                re;
  logic [csq_pkg::PtrBits-1:0]         raddr;
  logic [csq_pkg::ThreadIdBits-1:0]    wdata;
  logic [csq_pkg::ThreadIdBits-1:0]    rdata;
  logic [15:0]                         init_masked;
  logic [7:0]                          tid_masked;

  // Pointer step that wraps at the queue depth.
  function automatic logic [csq_pkg::PtrBits-1:0] ptr_inc(
    input logic [csq_pkg::PtrBits-1:0] ptr
  );
    if (ptr == csq_pkg::PtrBits'(csq_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign init_masked = cmdq_i.cmd.init_count & csq_pkg::InitMask;
  assign tid_masked  = cmdq_i.cmd.thread_id & csq_pkg::IdMask;
  assign wdata       = csq_pkg::ThreadIdBits'(tid_masked);
  assign count_inc   = (count_q != CountMax) ? count_q + 1'b1 : count_q;

  // Wait queue storage.
  csq_ram #(
    .Width (csq_pkg::ThreadIdBits),
    .Depth (csq_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Execute one request, or release one queued thread per cycle.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    open_d      = open_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = head_q;

    unique case (state_q)
      csq_pkg::BK_IDLE: begin
        if (cmdq_i.valid) begin
          pop_o      = 1'b1;
          res_d.last = 1'b1;
          if (cmdq_i.cmd.op == csq_pkg::OP_OPEN) begin
            count_d     = csq_pkg::CntBits'(init_masked);
            open_d      = 1'b1;
            head_d      = '0;
            tail_d      = '0;
            occ_d       = '0;
            res_valid_d = 1'b1;
          end else if (!open_q) begin
            res_d.status = csq_pkg::STATUS_CLOSED;
            res_valid_d  = 1'b1;
          end else begin
            unique case (cmdq_i.cmd.op)
              csq_pkg::OP_WAIT: begin
                res_valid_d = 1'b1;
                if (count_q <= 0) begin
                  if (occ_q == csq_pkg::OccBits'(csq_pkg::QueueDepth)) begin
                    res_d.status = csq_pkg::STATUS_FULL;
                  end else begin
                    count_d       = count_q - 1'b1;
                    we            = 1'b1;
                    tail_d        = ptr_inc(tail_q);
                    occ_d         = occ_q + 1'b1;
                    res_d.blocked = 1'b1;
                  end
                end else begin
                  count_d = count_q - 1'b1;
                end
              end
              csq_pkg::OP_SIGNAL: begin
                count_d = count_inc;
                if (count_inc <= 0 && occ_q != '0) begin
                  re      = 1'b1;
                  state_d = csq_pkg::BK_POP;
                end else begin
                  res_valid_d = 1'b1;
                end
              end
              csq_pkg::OP_CLOSE: begin
                if (occ_q == '0) begin
                  count_d     = '0;
                  open_d      = 1'b0;
                  head_d      = '0;
                  tail_d      = '0;
                  res_valid_d = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = csq_pkg::BK_DRAIN;
                end
              end
              default: begin
                res_valid_d = 1'b1;
              end
            endcase
          end
        end
      end

      // A signal releases the oldest waiter once its id is read.
      csq_pkg::BK_POP: begin
        res_valid_d           = 1'b1;
        res_d.released_valid  = 1'b1;
        res_d.released_thread = 8'(rdata);
        res_d.last            = 1'b1;
        head_d                = ptr_inc(head_q);
        occ_d                 = occ_q - 1'b1;
        state_d               = csq_pkg::BK_IDLE;
      end

      // A close releases every waiter, reading the next one ahead.
      csq_pkg::BK_DRAIN: begin
        res_valid_d           = 1'b1;
        res_d.released_valid  = 1'b1;
        res_d.released_thread = 8'(rdata);
        res_d.last            = (occ_q == csq_pkg::OccBits'(1));
        if (occ_q == csq_pkg::OccBits'(1)) begin
          count_d = '0;
          open_d  = 1'b0;
          head_d  = '0;
          tail_d  = '0;
          occ_d   = '0;
          state_d = csq_pkg::BK_IDLE;
        end else begin
          re     = 1'b1;
          raddr  = ptr_inc(head_q);
          head_d = ptr_inc(head_q);
          occ_d  = occ_q - 1'b1;
        end
      end

      default: begin
        state_d = csq_pkg::BK_IDLE;
      end
    endcase
  end

  // Control and semaphore state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csq_pkg::BK_IDLE;
      count_q     <= '0;
      open_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      open_q      <= open_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/counting_semaphore_wait_queue.sv
`timescale 1ns / 1ps

// Counting semaphore with a FIFO of blocked thread ids.
// A request (open, wait, signal or close) is taken at a rising edge where
// start_i is high and busy_o is low. The front part queues up to two
// classified requests; busy_o is high while that queue is full.
// Each result appears on res_o for exactly one cycle with res_valid_o high.
// Every request gives at least one result, and its final one has last set.
// When the back unit is free, a taken request goes from the front queue to
// the back unit, whose result register drives res_o. Open, wait and a
// signal that releases nothing finish in the idle state; a signal that
// releases a waiter also passes the pop state, since the id comes from the
// wait queue RAM with a registered read. A close with N queued waiters gives
// N results back to back (one when the queue is empty).
// Reset clears the count, the queue pointers and the request queue, and
// leaves the semaphore closed; the wait queue contents are not cleared.
// The receiver cannot hold results off, so the block never waits on it.
module counting_semaphore_wait_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  csq_pkg::csq_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output csq_pkg::csq_res_t res_o
);

  csq_pkg::csq_cmdq_t cmdq;
  logic               pop;

  // Accept and classify requests.
  csq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .cmdq_o  (cmdq),
    .pop_i   (pop)
  );

  // Carry out requests against the semaphore state.
  csq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmdq_i      (cmdq),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
